>>> hw/rtl/insertion_sorter_top_macros.svh
// ----------------------------------------------------------------------------
// insertion sorter assertion macros
// shared clocked assertion forms for the sorter rtl
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_TOP_MACROS_SVH
`define INSERTION_SORTER_TOP_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ISORT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ISORT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// types and constants shared by the insertion sorter cells and top level
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic insert;
		logic shift_out;
	} cell_ctl_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

endpackage

>>> hw/rtl/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorted chain: compares the arriving key, keeps its entry,
// takes its left neighbor or the key on insert, takes its right neighbor on drain
// ----------------------------------------------------------------------------
module isort_cell
	import isort_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  data_t     key,
	input  logic      prev_gt,
	input  data_t     prev_value,
	input  logic      prev_valid,
	input  data_t     next_value,
	input  logic      next_valid,
	output logic      gt,
	output data_t     value,
	output logic      valid
);

	data_t value_q;
	logic  valid_q;

	// empty slots count as greater, so the key lands after every entry <= key
	assign gt    = !valid_q || (value_q > key);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_out) begin
			valid_q <= next_valid;
		end else if (ctl.insert && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_out) begin
			value_q <= next_value;
		end else if (ctl.insert && gt) begin
			value_q <= prev_gt ? prev_value : key;
		end
	end

endmodule

>>> hw/rtl/insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// insertion_sorter_top
// stable streaming insertion sorter built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  value, last_item
// out      out  out_valid/out_stall sorted_value, end_of_list, overflowed
//
// one input beat per cycle while filling: each cell compares and shifts at once
// a last_item beat starts the drain: one output beat per cycle while out_stall is low, smallest first
// the drain takes as many beats as entries stored, at most CAPACITY
// input is stalled for the whole drain; output beats hold while out_stall is high
// reset empties the chain and clears the overflow flag
// ----------------------------------------------------------------------------
`include "insertion_sorter_top_macros.svh"

module insertion_sorter_top
	import isort_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  data_t value,
	input  logic  last_item,
	input  logic  in_valid,
	output logic  in_stall,
	output data_t sorted_value,
	output logic  end_of_list,
	output logic  overflowed,
	output logic  out_valid,
	input  logic  out_stall
);

	state_t    state_q;
	state_t    state_d;
	logic      ovf_q;
	cell_ctl_t ctl;
	logic      in_accept;
	logic      out_accept;
	logic      full;

	data_t               cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_gt;
	logic [CAPACITY:0]   valid_plus;

	assign full       = cell_valid[CAPACITY-1];
	assign in_accept  = in_valid && !in_stall;
	assign out_accept = out_valid && !out_stall;

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b0;
		out_valid     = 1'b0;
		ctl.insert    = 1'b0;
		ctl.shift_out = 1'b0;
		case (state_q)
			ST_FILL: begin
				ctl.insert = in_valid && !full;
				if (in_valid && last_item) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				in_stall      = 1'b1;
				out_valid     = cell_valid[0];
				ctl.shift_out = cell_valid[0] && !out_stall;
				if (ctl.shift_out && end_of_list) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (in_accept && full) begin
			ovf_q <= 1'b1;
		end else if (out_accept && end_of_list) begin
			ovf_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  prev_gt;
		data_t prev_value;
		logic  prev_valid;
		data_t next_value;
		logic  next_valid;

		if (i == 0) begin : g_head
			assign prev_gt    = 1'b0;
			assign prev_value = '0;
			assign prev_valid = 1'b0;
		end else begin : g_body
			assign prev_gt    = cell_gt[i-1];
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		isort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (value),
			.prev_gt    (prev_gt),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.next_value (next_value),
			.next_valid (next_valid),
			.gt         (cell_gt[i]),
			.value      (cell_value[i]),
			.valid      (cell_valid[i])
		);
	end

	assign sorted_value = cell_value[0];
	assign end_of_list  = !cell_valid[1];
	assign overflowed   = ovf_q;

	// occupied slots always form a run from slot zero
	assign valid_plus = {1'b0, cell_valid} + (CAPACITY+1)'(1);

	`ISORT_ASSERT(a_valid_contiguous, $onehot(valid_plus), "occupied slots not contiguous")
	`ISORT_ASSERT(a_last_starts_drain, in_accept && last_item |=> out_valid, "no drain after last beat")
	`ISORT_ASSERT(a_drain_ends, out_accept && end_of_list |=> !out_valid && cell_valid == '0, "chain not empty after final beat")
	`ISORT_ASSERT(a_drain_continues, out_accept && !end_of_list |=> out_valid, "drain stopped early")

endmodule
